FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the delimited text field parser.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_HOLDS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_HOLDS(label, clk, rst, prop)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/dtfp_pkg.sv
// Types, codes and helpers of the delimited text field parser.
// No dependencies; used by the interfaces, the engine and the top level.
`default_nettype none

package dtfp_pkg;

  localparam int CHAR_W      = 16;
  localparam int LEN_W       = 13;
  localparam int LIMIT_W     = 16;
  localparam int CFG_IDX_W   = 4;
  localparam int MAX_EVENTS  = 4;
  localparam int EV_CNT_W    = 3;
  localparam int EV_IDX_W    = 2;

  localparam logic [CHAR_W-1:0]  CH_QUOTE       = 16'h0022;
  localparam logic [CHAR_W-1:0]  CH_CR          = 16'h000D;
  localparam logic [CHAR_W-1:0]  CH_LF          = 16'h000A;
  localparam logic [CHAR_W-1:0]  CH_TAB         = 16'h0009;
  localparam logic [LEN_W-1:0]   CELL_LEN_RESET = 13'd4096;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET    = 16'hFFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_DELIMITER = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_LEN  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CELLS = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ROWS  = 4'd3;

  typedef enum logic [1:0] {
    EV_CHAR  = 2'd0,
    EV_FIELD = 2'd1,
    EV_ROW   = 2'd2,
    EV_DONE  = 2'd3
  } ev_kind_t;

  typedef enum logic [1:0] {
    STOP_RUN = 2'd0,
    STOP_EOT = 2'd1,
    STOP_CR  = 2'd2
  } stop_mode_t;

  typedef struct packed {
    ev_kind_t            kind;
    logic [CHAR_W-1:0]   ch;
    logic                truncated;
    logic [LIMIT_W-1:0]  row_count;
  } evt_t;

  typedef struct packed {
    evt_t [MAX_EVENTS-1:0] ev;
    logic [EV_CNT_W-1:0]   count;
  } batch_t;

  typedef struct packed {
    logic [CHAR_W-1:0]  delimiter_char;
    logic [LEN_W-1:0]   max_cell_length;
    logic [LIMIT_W-1:0] max_cells;
    logic [LIMIT_W-1:0] max_rows;
  } cfg_t;

  function automatic batch_t push_evt(batch_t b, ev_kind_t k, logic [CHAR_W-1:0] c,
                                      logic tr, logic [LIMIT_W-1:0] rc);
    batch_t r;
    r = b;
    if (b.count < EV_CNT_W'(MAX_EVENTS)) begin
      r.ev[b.count[EV_IDX_W-1:0]].kind      = k;
      r.ev[b.count[EV_IDX_W-1:0]].ch        = c;
      r.ev[b.count[EV_IDX_W-1:0]].truncated = tr;
      r.ev[b.count[EV_IDX_W-1:0]].row_count = rc;
      r.count = b.count + 1'b1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/dtfp_if.sv
// Channel interfaces of the delimited text field parser: characters in,
// events out, register writes. Depends on dtfp_pkg.
`default_nettype none

interface dtfp_char_if import dtfp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              end_of_text;

  modport source (output valid, char_code, end_of_text, input ready);
  modport sink   (input valid, char_code, end_of_text, output ready);
endinterface

interface dtfp_event_if import dtfp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         event_kind;
  logic [CHAR_W-1:0]  char_out;
  logic               truncated;
  logic [LIMIT_W-1:0] row_count;
  logic               last_of_run;

  modport source (output valid, event_kind, char_out, truncated, row_count, last_of_run,
                  input ready);
  modport sink   (input valid, event_kind, char_out, truncated, row_count, last_of_run,
                  output ready);
endinterface

interface dtfp_cfg_if import dtfp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [LIMIT_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/dtfp_engine.sv
// Parse state and per-character step logic: one accepted character yields
// the next state and a batch of up to four events. Depends on dtfp_pkg.
`default_nettype none

module dtfp_engine import dtfp_pkg::*; #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [CHAR_W-1:0] ch,
  input  logic              eot,
  input  cfg_t              cfg,
  output batch_t            batch
);

  localparam int CMP_W = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;

  logic                   in_quotes, in_quotes_next;
  logic                   quote_pending, quote_pending_next;
  logic                   cr_pending, cr_pending_next;
  stop_mode_t             stop_mode, stop_mode_next;
  logic [LEN_W-1:0]       field_length, field_length_next;
  logic [COUNT_WIDTH-1:0] row_field_count, row_field_count_next;
  logic [COUNT_WIDTH-1:0] total_cells, total_cells_next;
  logic [COUNT_WIDTH-1:0] rows_done, rows_done_next;
  logic                   trunc_flag, trunc_flag_next;
  logic                   skip, stopped;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(logic [COUNT_WIDTH-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  always_comb begin
    in_quotes_next       = in_quotes;
    quote_pending_next   = quote_pending;
    cr_pending_next      = cr_pending;
    stop_mode_next       = stop_mode;
    field_length_next    = field_length;
    row_field_count_next = row_field_count;
    total_cells_next     = total_cells;
    rows_done_next       = rows_done;
    trunc_flag_next      = trunc_flag;
    batch                = '0;
    skip                 = 1'b0;
    stopped              = 1'b0;

    if (accept) begin
      unique case (stop_mode)
        STOP_EOT: begin
        end
        STOP_CR: begin
          if (!(ch == CH_LF && eot)) trunc_flag_next = 1'b1;
          batch = push_evt(batch, EV_DONE, '0, trunc_flag_next,
                           LIMIT_W'(rows_done_next));
          stop_mode_next = STOP_EOT;
        end
        default: begin
          if (cr_pending) begin
            cr_pending_next = 1'b0;
            if (ch == CH_LF) skip = 1'b1;
          end
          if (quote_pending) begin
            quote_pending_next = 1'b0;
            if (ch == CH_QUOTE) begin
              if (field_length_next < cfg.max_cell_length) begin
                batch = push_evt(batch, EV_CHAR, CH_QUOTE, 1'b0, '0);
                field_length_next = field_length_next + 1'b1;
              end else begin
                trunc_flag_next = 1'b1;
              end
              in_quotes_next = 1'b1;
              skip = 1'b1;
            end
          end
          if (!skip) begin
            priority if (in_quotes_next) begin
              if (ch == CH_QUOTE) begin
                in_quotes_next     = 1'b0;
                quote_pending_next = 1'b1;
              end else if (field_length_next < cfg.max_cell_length) begin
                batch = push_evt(batch, EV_CHAR, ch, 1'b0, '0);
                field_length_next = field_length_next + 1'b1;
              end else begin
                trunc_flag_next = 1'b1;
              end
            end else if (ch == CH_QUOTE && field_length_next == '0) begin
              in_quotes_next = 1'b1;
            end else if (ch == cfg.delimiter_char) begin
              batch = push_evt(batch, EV_FIELD, '0, 1'b0, '0);
              field_length_next    = '0;
              row_field_count_next = sat_inc(row_field_count_next);
              total_cells_next     = sat_inc(total_cells_next);
              if (CMP_W'(total_cells_next) >= CMP_W'(cfg.max_cells)) begin
                trunc_flag_next = 1'b1;
                batch = push_evt(batch, EV_ROW, '0, 1'b0, '0);
                row_field_count_next = '0;
                rows_done_next       = sat_inc(rows_done_next);
                batch = push_evt(batch, EV_DONE, '0, trunc_flag_next,
                                 LIMIT_W'(rows_done_next));
                stopped = 1'b1;
              end
            end else if (ch != CH_CR && ch != CH_LF) begin
              if (field_length_next < cfg.max_cell_length) begin
                batch = push_evt(batch, EV_CHAR, ch, 1'b0, '0);
                field_length_next = field_length_next + 1'b1;
              end else begin
                trunc_flag_next = 1'b1;
              end
            end else begin
              batch = push_evt(batch, EV_FIELD, '0, 1'b0, '0);
              field_length_next = '0;
              total_cells_next  = sat_inc(total_cells_next);
              batch = push_evt(batch, EV_ROW, '0, 1'b0, '0);
              row_field_count_next = '0;
              rows_done_next       = sat_inc(rows_done_next);
              if (ch == CH_CR) cr_pending_next = 1'b1;
              if (CMP_W'(rows_done_next) >= CMP_W'(cfg.max_rows) ||
                  CMP_W'(total_cells_next) >= CMP_W'(cfg.max_cells)) begin
                stopped = 1'b1;
                priority if (eot) begin
                  batch = push_evt(batch, EV_DONE, '0, trunc_flag_next,
                                   LIMIT_W'(rows_done_next));
                end else if (ch == CH_LF) begin
                  trunc_flag_next = 1'b1;
                  batch = push_evt(batch, EV_DONE, '0, trunc_flag_next,
                                   LIMIT_W'(rows_done_next));
                end else begin
                  stop_mode_next = STOP_CR;
                end
              end
            end
          end
          if (!stopped && eot) begin
            if (field_length_next != '0 || row_field_count_next != '0) begin
              batch = push_evt(batch, EV_FIELD, '0, 1'b0, '0);
              field_length_next    = '0;
              total_cells_next     = sat_inc(total_cells_next);
              batch = push_evt(batch, EV_ROW, '0, 1'b0, '0);
              row_field_count_next = '0;
              rows_done_next       = sat_inc(rows_done_next);
            end
            batch = push_evt(batch, EV_DONE, '0, trunc_flag_next,
                             LIMIT_W'(rows_done_next));
          end
          if (stopped && stop_mode_next != STOP_CR) stop_mode_next = STOP_EOT;
        end
      endcase

      if (eot) begin
        in_quotes_next       = 1'b0;
        quote_pending_next   = 1'b0;
        cr_pending_next      = 1'b0;
        stop_mode_next       = STOP_RUN;
        field_length_next    = '0;
        row_field_count_next = '0;
        total_cells_next     = '0;
        rows_done_next       = '0;
        trunc_flag_next      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_quotes       <= 1'b0;
      quote_pending   <= 1'b0;
      cr_pending      <= 1'b0;
      stop_mode       <= STOP_RUN;
      field_length    <= '0;
      row_field_count <= '0;
      total_cells     <= '0;
      rows_done       <= '0;
      trunc_flag      <= 1'b0;
    end else begin
      in_quotes       <= in_quotes_next;
      quote_pending   <= quote_pending_next;
      cr_pending      <= cr_pending_next;
      stop_mode       <= stop_mode_next;
      field_length    <= field_length_next;
      row_field_count <= row_field_count_next;
      total_cells     <= total_cells_next;
      rows_done       <= rows_done_next;
      trunc_flag      <= trunc_flag_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/delimited_text_field_parser_core.sv
// Top level of the delimited text field parser: register file, parse engine
// and the two-batch event buffer. Depends on dtfp_pkg, the dtfp interfaces,
// dtfp_engine and assert_macros.svh.
//
// One character is taken per cycle while the event buffer has room. Each
// character is parsed in the cycle it is accepted and leaves between zero and
// four events (character, field end, row end, done); its events are held as
// one batch in a staging register and then drained through the output
// register, one event beat per cycle while events.ready is high, the last one
// marked by last_of_run. Throughput is one character per cycle while characters
// yield at most one event each and the output is not stalled; a character with
// n events holds the output for n beats. A character with no events still waits
// while the staging register is full and the output is not on its last beat.
// Register writes are taken every cycle and must only happen while the
// parser is idle.
`default_nettype none
`include "assert_macros.svh"

module delimited_text_field_parser_core import dtfp_pkg::*; #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  dtfp_char_if.sink   chars,
  dtfp_event_if.source events,
  dtfp_cfg_if.sink    cfg
);

  cfg_t                cfg_regs;
  batch_t              step_batch;
  batch_t              stage;
  logic                stage_valid;
  batch_t              out_batch;
  logic                out_valid;
  logic [EV_IDX_W-1:0] out_idx;
  logic                in_beat;
  logic                out_beat;
  logic                out_is_last;
  logic                out_last;
  logic                out_load;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.delimiter_char  <= CH_TAB;
      cfg_regs.max_cell_length <= CELL_LEN_RESET;
      cfg_regs.max_cells       <= LIMIT_RESET;
      cfg_regs.max_rows        <= LIMIT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_DELIMITER: cfg_regs.delimiter_char  <= cfg.data;
        CFG_CELL_LEN:  cfg_regs.max_cell_length <= cfg.data[LEN_W-1:0];
        CFG_MAX_CELLS: cfg_regs.max_cells       <= cfg.data;
        CFG_MAX_ROWS:  cfg_regs.max_rows        <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  dtfp_engine #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_engine (
    .clk    (clk),
    .rst    (rst),
    .accept (in_beat),
    .ch     (chars.char_code),
    .eot    (chars.end_of_text),
    .cfg    (cfg_regs),
    .batch  (step_batch)
  );

  assign out_is_last = (EV_CNT_W'(out_idx) + 1'b1) == out_batch.count;
  assign out_beat    = events.valid && events.ready;
  assign out_last    = out_beat && out_is_last;
  assign out_load    = stage_valid && (!out_valid || out_last);
  assign chars.ready = !stage_valid || out_load;
  assign in_beat     = chars.valid && chars.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_beat && step_batch.count != '0) begin
      stage_valid <= 1'b1;
    end else if (out_load) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat && step_batch.count != '0) begin
      stage <= step_batch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      out_idx   <= '0;
    end else if (out_load) begin
      out_valid <= 1'b1;
      out_idx   <= '0;
    end else if (out_last) begin
      out_valid <= 1'b0;
    end else if (out_beat) begin
      out_idx <= out_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_batch <= stage;
    end
  end

  assign events.valid       = out_valid;
  assign events.event_kind  = out_batch.ev[out_idx].kind;
  assign events.char_out    = out_batch.ev[out_idx].ch;
  assign events.truncated   = out_batch.ev[out_idx].truncated;
  assign events.row_count   = out_batch.ev[out_idx].row_count;
  assign events.last_of_run = out_is_last;

  `ASSERT_IMPLIES(a_out_batch_nonempty, clk, rst, out_valid, out_batch.count != '0)
  `ASSERT_IMPLIES(a_out_idx_in_range, clk, rst, out_valid,
                  EV_CNT_W'(out_idx) < out_batch.count)
  `ASSERT_NEXT(a_drain_empties, clk, rst, out_last && !stage_valid, !out_valid)
  `ASSERT_NEXT(a_stage_moves, clk, rst, out_load && !(in_beat && step_batch.count != '0),
               !stage_valid && out_valid)

endmodule

`default_nettype wire

FILE: test/delimited_text_field_parser_core_test.sv
// Self-checking testbench for delimited_text_field_parser_core: directed and random texts
// under several register settings, with a built-in parse predictor and an event scoreboard.
// Depends on dtfp_pkg, the dtfp interfaces and the RTL of the parser.
module delimited_text_field_parser_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import dtfp_pkg::*;

  localparam int unsigned COUNT_TOP   = 65535;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_CHARS = 30;
  localparam int unsigned SETTLE      = 8;

  typedef struct {
    ev_kind_t           kind;
    logic [CHAR_W-1:0]  ch;
    logic               trunc;
    logic [LIMIT_W-1:0] rows;
    logic               last;
  } parse_event_t;

  class parse_event_book;
    logic [CHAR_W-1:0]  delim;
    logic [LEN_W-1:0]   cell_len;
    logic [LIMIT_W-1:0] cells_lim;
    logic [LIMIT_W-1:0] rows_lim;
    bit quoted, quote_wait, cr_wait, cut;
    stop_mode_t stop;
    int unsigned field_len, row_fields, cells, rows;
    parse_event_t step_events[$];
    parse_event_t events_due[$];
    int unsigned failures;

    function new();
      delim     = CH_TAB;
      cell_len  = CELL_LEN_RESET;
      cells_lim = LIMIT_RESET;
      rows_lim  = LIMIT_RESET;
      failures  = 0;
      rearm();
    endfunction

    function void rearm();
      quoted     = 0;
      quote_wait = 0;
      cr_wait    = 0;
      cut        = 0;
      stop       = STOP_RUN;
      field_len  = 0;
      row_fields = 0;
      cells      = 0;
      rows       = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [LIMIT_W-1:0] val);
      case (idx)
        CFG_DELIMITER: delim = val;
        CFG_CELL_LEN:  cell_len = val[LEN_W-1:0];
        CFG_MAX_CELLS: cells_lim = val;
        CFG_MAX_ROWS:  rows_lim = val;
        default: ;
      endcase
    endfunction

    function int unsigned sat_inc(int unsigned v);
      return (v >= COUNT_TOP) ? COUNT_TOP : v + 1;
    endfunction

    function void add(ev_kind_t k, logic [CHAR_W-1:0] c, logic tr, logic [LIMIT_W-1:0] rc);
      parse_event_t e;
      e.kind  = k;
      e.ch    = c;
      e.trunc = tr;
      e.rows  = rc;
      e.last  = 0;
      if (step_events.size() < MAX_EVENTS) step_events = {step_events, e};
    endfunction

    function void keep_char(logic [CHAR_W-1:0] c);
      if (field_len < cell_len) begin
        add(EV_CHAR, c, 1'b0, '0);
        field_len++;
      end else begin
        cut = 1;
      end
    endfunction

    function void close_field();
      add(EV_FIELD, '0, 1'b0, '0);
      field_len  = 0;
      row_fields = sat_inc(row_fields);
      cells      = sat_inc(cells);
    endfunction

    function void close_row();
      add(EV_ROW, '0, 1'b0, '0);
      row_fields = 0;
      rows       = sat_inc(rows);
    endfunction

    function void add_done();
      add(EV_DONE, '0, cut, LIMIT_W'(rows));
    endfunction

    function void take_char(logic [CHAR_W-1:0] c, bit eot);
      bit skip, stopped;
      skip    = 0;
      stopped = 0;
      step_events.delete();
      if (stop == STOP_EOT) begin
        if (eot) rearm();
        return;
      end
      if (stop == STOP_CR) begin
        if (!(c == CH_LF && eot)) cut = 1;
        add_done();
        stop = STOP_EOT;
      end else begin
        if (cr_wait) begin
          cr_wait = 0;
          if (c == CH_LF) skip = 1;
        end
        if (quote_wait) begin
          quote_wait = 0;
          if (c == CH_QUOTE) begin
            keep_char(CH_QUOTE);
            quoted = 1;
            skip   = 1;
          end
        end
        if (!skip) begin
          if (quoted) begin
            if (c == CH_QUOTE) begin
              quoted     = 0;
              quote_wait = 1;
            end else begin
              keep_char(c);
            end
          end else if (c == CH_QUOTE && field_len == 0) begin
            quoted = 1;
          end else if (c == delim) begin
            close_field();
            if (cells >= cells_lim) begin
              cut = 1;
              close_row();
              add_done();
              stopped = 1;
            end
          end else if (c != CH_CR && c != CH_LF) begin
            keep_char(c);
          end else begin
            close_field();
            close_row();
            if (c == CH_CR) cr_wait = 1;
            if (rows >= rows_lim || cells >= cells_lim) begin
              stopped = 1;
              if (eot) begin
                add_done();
              end else if (c == CH_LF) begin
                cut = 1;
                add_done();
              end else begin
                stop = STOP_CR;
              end
            end
          end
        end
        if (!stopped && eot) begin
          if (field_len != 0 || row_fields != 0) begin
            close_field();
            close_row();
          end
          add_done();
        end
        if (stopped && stop != STOP_CR) stop = STOP_EOT;
      end
      if (eot) rearm();
      if (step_events.size() > 0) step_events[$].last = 1;
      events_due = {events_due, step_events};
    endfunction

    function void match_event(logic [1:0] kind, logic [CHAR_W-1:0] c, logic tr,
                              logic [LIMIT_W-1:0] rc, logic last);
      parse_event_t want;
      if (events_due.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected event: kind %0d char %h trunc %0b rows %0d last %0b",
                   kind, c, tr, rc, last);
        return;
      end
      want = events_due.pop_front();
      if (kind !== want.kind || c !== want.ch || tr !== want.trunc ||
          rc !== want.rows || last !== want.last) begin
        failures++;
        if (failures <= 10)
          $display("mismatch: expected kind %0d char %h trunc %0b rows %0d last %0b, %s",
                   want.kind, want.ch, want.trunc, want.rows, want.last,
                   $sformatf("got kind %0d char %h trunc %0b rows %0d last %0b",
                             kind, c, tr, rc, last));
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  dtfp_char_if  chars_bus();
  dtfp_event_if events_bus();
  dtfp_cfg_if   cfg_bus();

  delimited_text_field_parser_core dut (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars_bus),
    .events (events_bus),
    .cfg    (cfg_bus)
  );

  parse_event_book book = new();
  bit          idle_on = 0;
  int unsigned stall_left = 0;
  int unsigned chars_sent = 0;
  int unsigned cycles = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    rst                    = 1'b1;
    chars_bus.valid        = 1'b0;
    chars_bus.char_code    = '0;
    chars_bus.end_of_text  = 1'b0;
    events_bus.ready       = 1'b0;
    cfg_bus.valid          = 1'b0;
    cfg_bus.index          = '0;
    cfg_bus.data           = '0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      events_bus.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 15) - 1;
      events_bus.ready <= 1'b0;
    end else begin
      events_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && events_bus.valid && events_bus.ready)
      book.match_event(events_bus.event_kind, events_bus.char_out, events_bus.truncated,
                       events_bus.row_count, events_bus.last_of_run);
  end

  // Call at a falling edge; returns at the falling edge after the beat.
  task automatic send_char(input logic [CHAR_W-1:0] c, input bit eot);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      chars_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    chars_bus.valid       <= 1'b1;
    chars_bus.char_code   <= c;
    chars_bus.end_of_text <= eot;
    @(posedge clk);
    while (!chars_bus.ready) @(posedge clk);
    book.take_char(c, eot);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input logic [CHAR_W-1:0] text[$]);
    foreach (text[i]) send_char(text[i], i == text.size() - 1);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    book.set_reg(idx, val);
    @(negedge clk);
  endtask

  // Drain all owed events, then let the pipeline empty before touching registers.
  task automatic settle();
    chars_bus.valid <= 1'b0;
    while (book.events_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic logic [CHAR_W-1:0] plain_char();
    logic [CHAR_W-1:0] c;
    c = $urandom_range(0, 1) ? CHAR_W'($urandom) : CHAR_W'($urandom_range(16'h61, 16'h7A));
    if (c == CH_QUOTE || c == CH_CR || c == CH_LF || c == book.delim)
      c = (book.delim == 16'h0061) ? 16'h0062 : 16'h0061;
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] noise_char();
    case ($urandom_range(0, 9))
      0, 1:    return book.delim;
      2, 3:    return CH_QUOTE;
      4:       return CH_CR;
      5:       return CH_LF;
      6, 7:    return CHAR_W'($urandom);
      default: return CHAR_W'($urandom_range(16'h61, 16'h7A));
    endcase
  endfunction

  task automatic send_random_text();
    logic [CHAR_W-1:0] text[$];
    int unsigned nrows, nfields, len;
    if ($urandom_range(0, 3) == 0) begin
      len = $urandom_range(1, 8);
      repeat (len) text = {text, noise_char()};
    end else begin
      nrows = $urandom_range(1, 2);
      for (int unsigned r = 0; r < nrows; r++) begin
        nfields = $urandom_range(1, 3);
        for (int unsigned f = 0; f < nfields; f++) begin
          if (f != 0) text = {text, book.delim};
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 10) : $urandom_range(0, 3);
          if ($urandom_range(0, 2) == 0) begin
            text = {text, CH_QUOTE};
            for (int unsigned k = 0; k < len; k++) begin
              case ($urandom_range(0, 5))
                0:       text = {text, CH_QUOTE, CH_QUOTE};
                1:       text = {text, book.delim};
                2:       text = {text, $urandom_range(0, 1) ? CH_CR : CH_LF};
                default: text = {text, plain_char()};
              endcase
            end
            if ($urandom_range(0, 7) != 0) text = {text, CH_QUOTE};
          end else begin
            for (int unsigned k = 0; k < len; k++) text = {text, plain_char()};
          end
        end
        if (r + 1 < nrows || $urandom_range(0, 1) == 1) begin
          case ($urandom_range(0, 2))
            0:       text = {text, CH_CR};
            1:       text = {text, CH_LF};
            default: text = {text, CH_CR, CH_LF};
          endcase
        end
      end
    end
    if (text.size() == 0) text = {text, plain_char()};
    send_text(text);
  endtask

  initial begin : stimulus
    logic [LIMIT_W-1:0] setups [PHASES][4] = '{
      '{16'h002C, 16'd4096, 16'hFFFF, 16'hFFFF},
      '{16'h0000, 16'd0,    16'd1,    16'd1},
      '{16'hFFFF, 16'd2,    16'd5,    16'd2},
      '{16'h003B, 16'd3,    16'hFFFF, 16'd1},
      '{16'h0022, 16'd4,    16'd3,    16'hFFFF},
      '{16'h0009, 16'd1,    16'hFFFF, 16'd3},
      '{16'h002C, 16'd3,    16'd4,    16'd2},
      '{16'h0009, 16'd4096, 16'hFFFF, 16'hFFFF}
    };
    int unsigned start;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_text('{16'h0041});
    send_text('{CH_QUOTE, 16'h0061, CH_QUOTE, CH_QUOTE, 16'h0062, CH_QUOTE, CH_TAB,
                CH_CR, CH_LF});
    send_text('{16'hFFFF, 16'h0000});
    send_text('{16'h0078, CH_QUOTE, 16'h0079});
    send_text('{CH_QUOTE, CH_TAB, 16'h007A});

    for (int unsigned p = 0; p < PHASES; p++) begin
      settle();
      if (p == 6) begin
        setups[p][0] = $urandom_range(0, 1) ? CHAR_W'($urandom) : 16'h002C;
        setups[p][1] = LIMIT_W'($urandom_range(0, 6));
        setups[p][2] = LIMIT_W'($urandom_range(1, 8));
        setups[p][3] = LIMIT_W'($urandom_range(1, 4));
      end
      write_reg(CFG_DELIMITER, setups[p][0]);
      write_reg(CFG_CELL_LEN,  setups[p][1]);
      write_reg(CFG_MAX_CELLS, setups[p][2]);
      write_reg(CFG_MAX_ROWS,  setups[p][3]);
      cfg_bus.valid <= 1'b0;
      idle_on = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
      if (p == 1) send_text('{16'h0061, 16'h0000, 16'h0062});
      if (p == 3) begin
        send_text('{16'h0061, CH_CR, CH_LF});
        send_text('{16'h0061, CH_CR, 16'h0062});
      end
      start = chars_sent;
      while (chars_sent - start < PHASE_CHARS) send_random_text();
    end

    chars_bus.valid <= 1'b0;
    while (book.events_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (book.failures == 0 && book.events_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
